[rtl/cbez_pkg.sv]
package cbez_pkg;

  // Coordinate format is fixed at 32 bits; a slope needs three guard bits before clipping
  localparam int COORD_W = 32;
  localparam int SAT_W = COORD_W + 3;

  // Defaults for the top-level parameters
  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int T_FRAC_BITS_DEF = 16;

  // Input field widths fixed by the interface
  localparam int ACTION_W = 2;
  localparam int POINT_INDEX_W = 6;
  localparam int SEGMENT_W = 4;
  localparam int SEGMENT_CODES = 1 << SEGMENT_W;

  // Item kinds; the remaining code is dropped
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_POINT = 2'd1,
    ACT_SLOPE = 2'd2
  } action_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'({1'b0, {(COORD_W-1){1'b1}}});
  localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_W'({1'b1, {(COORD_W-1){1'b0}}});

  // Clip a widened coordinate into the signed 32-bit range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[COORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/cbez_lerp.sv]
// Three-stage linear interpolation lane: a + round_half_up((b - a) * t), or the exact b - a when sel_diff is set.
// Stage 1 forms the exact difference, stage 2 multiplies by t, stage 3 adds
// a and the rounding half in one sum and drops the fraction bits.
module cbez_lerp #(
  parameter int AW = 32,
  parameter int TW = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [AW-1:0] b,
  input  logic        [TW:0]   t,
  input  logic                 sel_diff,
  output logic signed [AW:0]   res
);

  localparam int DW = AW + 1;
  localparam int PW = DW + TW + 2;

  logic signed [AW-1:0] a_s1;
  logic signed [DW-1:0] d_s1;
  logic        [TW:0]   t_s1;
  logic signed [AW-1:0] a_s2;
  logic signed [DW-1:0] d_s2;
  logic signed [PW-1:0] prod_s2;
  logic signed [TW+1:0] t_sx;
  logic signed [PW-1:0] offset;
  logic signed [PW-1:0] sum;

  // Stage 1: exact difference
  always_ff @(posedge clk) begin
    if (en) begin
      a_s1 <= a;
      d_s1 <= $signed({b[AW-1], b}) - $signed({a[AW-1], a});
      t_s1 <= t;
    end
  end

  // Stage 2: scale by t
  assign t_sx = $signed({1'b0, t_s1});

  always_ff @(posedge clk) begin
    if (en) begin
      a_s2    <= a_s1;
      d_s2    <= d_s1;
      prod_s2 <= d_s1 * t_sx;
    end
  end

  // Stage 3: a * 2^TW plus one half, added in a single sum, then floor shift
  assign offset = {{(PW-AW-TW){a_s2[AW-1]}}, a_s2, 1'b1, {(TW-1){1'b0}}};
  assign sum = prod_s2 + offset;

  always_ff @(posedge clk) begin
    if (en) begin
      res <= sel_diff ? d_s2 : sum[TW +: DW];
    end
  end

endmodule

[rtl/cubic_bezier_point_and_slope_core.sv]
// A point or slope beat passes the store read, the lerp levels and the output register.
// One beat per cycle unless the output beat is stalled; loads produce no output beat.
// The whole datapath advances together and freezes only while the output beat is stalled.
// Reset clears the pipeline valid bits and the output valid; the control-point store
// is not cleared and holds nothing defined until each slot is loaded.
module cubic_bezier_point_and_slope_core #(
  parameter int MAX_SEGMENTS = cbez_pkg::MAX_SEGMENTS_DEF,
  parameter int T_FRAC_BITS  = cbez_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [cbez_pkg::ACTION_W-1:0]          action,
  input  logic [cbez_pkg::POINT_INDEX_W-1:0]     point_index,
  input  logic [cbez_pkg::SEGMENT_W-1:0]         segment,
  input  logic [T_FRAC_BITS:0]                   param_t,
  input  logic signed [cbez_pkg::COORD_W-1:0]    in_x,
  input  logic signed [cbez_pkg::COORD_W-1:0]    in_y,
  input  logic signed [cbez_pkg::COORD_W-1:0]    in_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [cbez_pkg::COORD_W-1:0]    out_x,
  output logic signed [cbez_pkg::COORD_W-1:0]    out_y,
  output logic signed [cbez_pkg::COORD_W-1:0]    out_z,
  output logic                                   is_slope
);

  localparam int CW = cbez_pkg::COORD_W;
  localparam int LW = CW + 1;
  localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int STORE_DEPTH = 4 * MAX_SEGMENTS;
  localparam int NSTG = 10;
  localparam int T_STG = 7;
  localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  logic                        adv;
  logic                        accept;
  logic                        is_eval;
  logic                        ld_we;
  logic [SEG_W-1:0]            wr_row;
  logic [SEG_W-1:0]            rd_row;
  logic [SEG_W-1:0]            seg_map [cbez_pkg::SEGMENT_CODES];
  logic [T_FRAC_BITS:0]        t_in;
  cbez_pkg::point_t            wr_pt;
  cbez_pkg::point_t            rd [4];

  logic [NSTG:1]               v;
  logic [NSTG:1]               sl;
  logic [T_FRAC_BITS:0]        t_pipe [1:T_STG];

  logic signed [CW-1:0]        p1 [3][4];
  logic signed [LW-1:0]        q  [3][3];
  logic signed [LW:0]          l2_res [3][2];
  logic signed [LW-1:0]        r  [3][2];
  logic signed [LW:0]          l3_res [3];
  logic signed [LW-1:0]        s  [3];
  logic signed [cbez_pkg::SAT_W-1:0] wide [3];

  // The whole pipeline moves unless the output beat is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign is_eval  = (action == cbez_pkg::ACT_POINT) || (action == cbez_pkg::ACT_SLOPE);

  // Clamp t above one
  assign t_in = (param_t > T_ONE) ? T_ONE : param_t;

  // Segment number folded into the number of stored segments
  for (genvar k = 0; k < cbez_pkg::SEGMENT_CODES; k++) begin : g_seg_map
    assign seg_map[k] = SEG_W'(k % MAX_SEGMENTS);
  end
  assign rd_row = seg_map[segment];

  // Load slot split into bank (low two bits) and row
  assign ld_we  = accept && (action == cbez_pkg::ACT_LOAD) &&
                  ($unsigned(32'(point_index)) < $unsigned(32'(STORE_DEPTH)));
  assign wr_row = SEG_W'(point_index[cbez_pkg::POINT_INDEX_W-1:2]);
  assign wr_pt  = '{x: in_x, y: in_y, z: in_z};

  // Four point banks, one per position inside a segment, read together
  for (genvar bk = 0; bk < 4; bk++) begin : g_bank
    cbez_pkg::point_t mem [MAX_SEGMENTS];
    logic             we;

    assign we = ld_we && (point_index[1:0] == 2'(bk));

    always_ff @(posedge clk) begin
      if (we) begin
        mem[wr_row] <= wr_pt;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rd[bk] <= mem[rd_row];
      end
    end

    assign p1[0][bk] = rd[bk].x;
    assign p1[1][bk] = rd[bk].y;
    assign p1[2][bk] = rd[bk].z;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v         <= {v[NSTG-1:1], in_valid && is_eval};
      out_valid <= v[NSTG];
    end
  end

  // Advance item kind and t alongside the data
  always_ff @(posedge clk) begin
    if (adv) begin
      sl        <= {sl[NSTG-1:1], action == cbez_pkg::ACT_SLOPE};
      t_pipe[1] <= t_in;
      for (int k = 2; k <= T_STG; k++) begin
        t_pipe[k] <= t_pipe[k-1];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_coord
    // First level: lerp of neighbors, or their exact difference for a slope
    for (genvar i = 0; i < 3; i++) begin : g_l1
      cbez_lerp #(.AW(CW), .TW(T_FRAC_BITS)) u_lerp (
        .clk      (clk),
        .en       (adv),
        .a        (p1[c][i]),
        .b        (p1[c][i+1]),
        .t        (t_pipe[1]),
        .sel_diff (sl[3]),
        .res      (q[c][i])
      );
    end

    // Second level
    for (genvar i = 0; i < 2; i++) begin : g_l2
      cbez_lerp #(.AW(LW), .TW(T_FRAC_BITS)) u_lerp (
        .clk      (clk),
        .en       (adv),
        .a        (q[c][i]),
        .b        (q[c][i+1]),
        .t        (t_pipe[4]),
        .sel_diff (1'b0),
        .res      (l2_res[c][i])
      );
      assign r[c][i] = l2_res[c][i][LW-1:0];
    end

    // Third level
    cbez_lerp #(.AW(LW), .TW(T_FRAC_BITS)) u_lerp3 (
      .clk      (clk),
      .en       (adv),
      .a        (r[c][0]),
      .b        (r[c][1]),
      .t        (t_pipe[T_STG]),
      .sel_diff (1'b0),
      .res      (l3_res[c])
    );
    assign s[c] = l3_res[c][LW-1:0];

    // Slope is three times the last level
    assign wide[c] = sl[NSTG] ?
                     ($signed({{2{s[c][LW-1]}}, s[c]}) + $signed({s[c][LW-1], s[c], 1'b0})) :
                     $signed({{2{s[c][LW-1]}}, s[c]});
  end

  // Output register with clipping
  always_ff @(posedge clk) begin
    if (adv) begin
      out_x    <= cbez_pkg::sat_coord(wide[0]);
      out_y    <= cbez_pkg::sat_coord(wide[1]);
      out_z    <= cbez_pkg::sat_coord(wide[2]);
      is_slope <= sl[NSTG];
    end
  end

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && (v == '0))
    else $error("pipeline not empty after reset");

  // A held output beat freezes every stage
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v) && out_valid)
    else $error("pipeline moved while output beat was held");

  // The last stage lands in the output register with its kind
  a_drain: assert property (@(posedge clk) disable iff (rst)
    adv && v[NSTG] |=> out_valid && (is_slope == $past(sl[NSTG])))
    else $error("result beat lost or kind changed at output");

  // Loads never enter the datapath
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && (action == cbez_pkg::ACT_LOAD) |=> !v[1])
    else $error("load beat entered the evaluation pipeline");

endmodule

[test/cbez_result_checker.sv]
`timescale 1ns / 100ps

module cbez_result_checker #(
  parameter int MAX_SEGMENTS = cbez_pkg::MAX_SEGMENTS_DEF,
  parameter int T_FRAC_BITS  = cbez_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [cbez_pkg::ACTION_W-1:0]       action,
  input  logic [cbez_pkg::POINT_INDEX_W-1:0]  point_index,
  input  logic [cbez_pkg::SEGMENT_W-1:0]      segment,
  input  logic [T_FRAC_BITS:0]                param_t,
  input  logic signed [cbez_pkg::COORD_W-1:0] in_x,
  input  logic signed [cbez_pkg::COORD_W-1:0] in_y,
  input  logic signed [cbez_pkg::COORD_W-1:0] in_z,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [cbez_pkg::COORD_W-1:0] out_x,
  input  logic signed [cbez_pkg::COORD_W-1:0] out_y,
  input  logic signed [cbez_pkg::COORD_W-1:0] out_z,
  input  logic                                is_slope,
  input  logic                                end_of_run,
  output int                                  errors,
  output int                                  pending,
  output int                                  loads_done,
  output int                                  points_done,
  output int                                  slopes_done
);

  localparam int     CW          = cbez_pkg::COORD_W;
  localparam int     STORE_DEPTH = 4 * MAX_SEGMENTS;
  localparam longint T_ONE       = longint'(1) << T_FRAC_BITS;
  localparam longint T_HALF      = longint'(1) << (T_FRAC_BITS - 1);
  localparam longint COORD_MAX   = 64'sd2147483647;
  localparam longint COORD_MIN   = -64'sd2147483648;
  localparam int     PRINT_LIMIT = 30;

  typedef struct {
    cbez_pkg::point_t p;
    logic             slope;
  } curve_beat_t;

  // Shadow copy of the control-point store
  logic signed [CW-1:0] ctrl_x [STORE_DEPTH];
  logic signed [CW-1:0] ctrl_y [STORE_DEPTH];
  logic signed [CW-1:0] ctrl_z [STORE_DEPTH];

  curve_beat_t expected_beats[$];
  logic        run_closed = 1'b0;

  task automatic report(string msg);
    if (errors < PRINT_LIMIT) begin
      $display("[%0t] ERROR %s", $time, msg);
    end
    errors++;
  endtask

  // One interpolation step, rounding half up toward +inf
  function automatic longint blend(longint a, longint b, longint t);
    return a + (((b - a) * t + T_HALF) >>> T_FRAC_BITS);
  endfunction

  function automatic logic signed [CW-1:0] clip_coord(longint v);
    if (v > COORD_MAX) begin
      return CW'(COORD_MAX);
    end
    if (v < COORD_MIN) begin
      return CW'(COORD_MIN);
    end
    return CW'(v);
  endfunction

  // Curve point or slope of one coordinate via de Casteljau
  function automatic logic signed [CW-1:0] bezier_coord(longint c0, longint c1,
                                                        longint c2, longint c3,
                                                        longint t, logic slope);
    longint a, b, c, d, e;
    if (slope) begin
      a = blend(c1 - c0, c2 - c1, t);
      b = blend(c2 - c1, c3 - c2, t);
      return clip_coord(3 * blend(a, b, t));
    end
    a = blend(c0, c1, t);
    b = blend(c1, c2, t);
    c = blend(c2, c3, t);
    d = blend(a, b, t);
    e = blend(b, c, t);
    return clip_coord(blend(d, e, t));
  endfunction

  always @(posedge clk) begin : watch
    int          base;
    longint      t;
    curve_beat_t beat;
    if (!rst) begin
      // Compare each accepted output beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          report($sformatf("unexpected output beat x=%h y=%h z=%h slope=%b",
                           out_x, out_y, out_z, is_slope));
        end else begin
          beat = expected_beats.pop_front();
          if (is_slope !== beat.slope) begin
            report($sformatf("is_slope got %b expected %b", is_slope, beat.slope));
          end
          if (out_x !== beat.p.x) begin
            report($sformatf("out_x got %h expected %h", out_x, beat.p.x));
          end
          if (out_y !== beat.p.y) begin
            report($sformatf("out_y got %h expected %h", out_y, beat.p.y));
          end
          if (out_z !== beat.p.z) begin
            report($sformatf("out_z got %h expected %h", out_z, beat.p.z));
          end
        end
      end

      // Update the store or predict a result for each accepted input beat
      if (in_valid && !in_stall) begin
        case (action)
          cbez_pkg::ACT_LOAD: begin
            if (point_index < STORE_DEPTH) begin
              ctrl_x[point_index] = in_x;
              ctrl_y[point_index] = in_y;
              ctrl_z[point_index] = in_z;
            end
            loads_done++;
          end
          cbez_pkg::ACT_POINT, cbez_pkg::ACT_SLOPE: begin
            t = longint'(param_t);
            if (t > T_ONE) begin
              t = T_ONE;
            end
            base = 4 * (int'(segment) % MAX_SEGMENTS);
            beat.slope = (action == cbez_pkg::ACT_SLOPE);
            beat.p.x = bezier_coord(ctrl_x[base], ctrl_x[base+1], ctrl_x[base+2],
                                    ctrl_x[base+3], t, beat.slope);
            beat.p.y = bezier_coord(ctrl_y[base], ctrl_y[base+1], ctrl_y[base+2],
                                    ctrl_y[base+3], t, beat.slope);
            beat.p.z = bezier_coord(ctrl_z[base], ctrl_z[base+1], ctrl_z[base+2],
                                    ctrl_z[base+3], t, beat.slope);
            expected_beats.insert(expected_beats.size(), beat);
            if (beat.slope) begin
              slopes_done++;
            end else begin
              points_done++;
            end
          end
          default: ;  // drop: unused code gives nothing
        endcase
      end
    end

    // Flag any prediction that never got its beat
    if (end_of_run && !run_closed) begin
      run_closed = 1'b1;
      if (expected_beats.size() != 0) begin
        report($sformatf("%0d expected beats never arrived", expected_beats.size()));
      end
    end
    pending = expected_beats.size();
  end

endmodule

[test/tb_cubic_bezier_point_and_slope_core.sv]
`timescale 1ns / 100ps

module tb_cubic_bezier_point_and_slope_core;

  localparam int AW = cbez_pkg::ACTION_W;
  localparam int PW = cbez_pkg::POINT_INDEX_W;
  localparam int SW = cbez_pkg::SEGMENT_W;
  localparam int CW = cbez_pkg::COORD_W;
  localparam int NSEG = cbez_pkg::MAX_SEGMENTS_DEF;
  localparam int T_FRAC = cbez_pkg::T_FRAC_BITS_DEF;
  localparam int T_ONE = 1 << T_FRAC;
  localparam logic [AW-1:0] ACT_UNUSED = 2'd3;
  localparam logic signed [CW-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] C_MIN = 32'sh8000_0000;
  localparam int ITEMS_PER_PHASE = 350;
  localparam int TAIL_CYCLES = 20;
  localparam int QUIET_LIMIT = 4000;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [AW-1:0]        action = cbez_pkg::ACT_LOAD;
  logic [PW-1:0]        point_index = '0;
  logic [SW-1:0]        segment = '0;
  logic [T_FRAC:0]      param_t = '0;
  logic signed [CW-1:0] in_x = '0;
  logic signed [CW-1:0] in_y = '0;
  logic signed [CW-1:0] in_z = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  logic                 is_slope;
  logic                 end_of_run = 1'b0;

  int errors, pending, loads_done, points_done, slopes_done;
  int idle_pct = 0;
  int stall_pct = 0;
  int items = 0;
  int quiet_cycles = 0;
  logic [4*NSEG-1:0] slot_loaded = '0;

  // Pacing per phase: free flow, sparse input, heavy output stall, mixed
  int idle_by_phase[4]  = '{0, 86, 0, 20};
  int stall_by_phase[4] = '{0, 0, 86, 20};

  cubic_bezier_point_and_slope_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .point_index(point_index), .segment(segment), .param_t(param_t),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .is_slope(is_slope)
  );

  cbez_result_checker check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .point_index(point_index), .segment(segment), .param_t(param_t),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .is_slope(is_slope),
    .end_of_run(end_of_run), .errors(errors), .pending(pending),
    .loads_done(loads_done), .points_done(points_done), .slopes_done(slopes_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the output side at the rate of the current phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] timeout: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one beat after a random gap and hold it until taken
  task automatic send_beat(logic [AW-1:0] act, logic [PW-1:0] idx,
                           logic [SW-1:0] seg, logic [T_FRAC:0] t,
                           logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                           logic signed [CW-1:0] z);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    point_index <= idx;
    segment     <= seg;
    param_t     <= t;
    in_x        <= x;
    in_y        <= y;
    in_z        <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_point(int slot, logic signed [CW-1:0] x,
                            logic signed [CW-1:0] y, logic signed [CW-1:0] z);
    send_beat(cbez_pkg::ACT_LOAD, PW'(slot), SW'($urandom), (T_FRAC+1)'($urandom),
              x, y, z);
    slot_loaded[slot] = 1'b1;
    items++;
  endtask

  task automatic eval_segment(logic [AW-1:0] act, int seg, int t);
    send_beat(act, PW'($urandom), SW'(seg), (T_FRAC+1)'(t),
              $urandom, $urandom, $urandom);
    items++;
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(5))
      0, 1: return r;
      2: return {{12{r[19]}}, r[19:0]};
      3: begin
        case (r[1:0])
          2'd0: return C_MAX;
          2'd1: return C_MIN;
          2'd2: return '0;
          default: return '1;
        endcase
      end
      default: return {(r[31] ? 2'b01 : 2'b10), r[29:0]};
    endcase
  endfunction

  // Mostly in range, with the ends and clamped values mixed in
  function automatic int rand_t();
    case ($urandom_range(9))
      0: return 0;
      1: return T_ONE;
      2: return T_ONE + 1 + $urandom_range(T_ONE - 2);
      default: return $urandom_range(T_ONE);
    endcase
  endfunction

  function automatic logic [AW-1:0] rand_kind();
    return $urandom_range(1) ? cbez_pkg::ACT_SLOPE : cbez_pkg::ACT_POINT;
  endfunction

  task automatic load_segment(int seg);
    for (int i = 0; i < 4; i++) begin
      load_point(4 * seg + i, rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // Pick a segment whose four points have all been written
  function automatic int ready_segment();
    int start, s;
    start = $urandom_range(NSEG - 1);
    for (int k = 0; k < NSEG; k++) begin
      s = (start + k) % NSEG;
      if (&slot_loaded[4*s +: 4]) begin
        return s;
      end
    end
    return 0;
  endfunction

  initial begin : stimulus
    int seg, pick, target;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Segment 0 at the coordinate extremes, so slopes clip both ways
    load_point(0, C_MAX, C_MIN, 32'sd0);
    load_point(1, C_MIN, C_MAX, -32'sd1);
    load_point(2, C_MAX, C_MIN, 32'sd1);
    load_point(3, C_MIN, C_MAX, 32'sh0001_0000);
    eval_segment(cbez_pkg::ACT_POINT, 0, 0);
    eval_segment(cbez_pkg::ACT_POINT, 0, T_ONE);
    eval_segment(cbez_pkg::ACT_POINT, 0, T_ONE / 2);
    eval_segment(cbez_pkg::ACT_POINT, 0, 2 * T_ONE - 1);
    eval_segment(cbez_pkg::ACT_SLOPE, 0, 0);
    eval_segment(cbez_pkg::ACT_SLOPE, 0, T_ONE);
    eval_segment(cbez_pkg::ACT_SLOPE, 0, 1);
    eval_segment(cbez_pkg::ACT_SLOPE, 0, T_ONE + 1);
    // Unused code must give no beat
    send_beat(ACT_UNUSED, PW'($urandom), SW'($urandom),
              (T_FRAC+1)'($urandom), $urandom, $urandom, $urandom);
    // Top slots, then a rewrite evaluated right behind the load
    load_segment(NSEG - 1);
    eval_segment(cbez_pkg::ACT_POINT, NSEG - 1, rand_t());
    eval_segment(cbez_pkg::ACT_SLOPE, NSEG - 1, rand_t());
    load_point(1, '0, '0, '0);
    eval_segment(cbez_pkg::ACT_POINT, 0, T_ONE / 3);

    // Random traffic, mostly whole segments followed by evaluations
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      target    = items + ITEMS_PER_PHASE;
      while (items < target) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          seg = $urandom_range(NSEG - 1);
          load_segment(seg);
          repeat ($urandom_range(6, 1)) eval_segment(rand_kind(), seg, rand_t());
        end else if (pick < 85) begin
          eval_segment(rand_kind(), ready_segment(), rand_t());
        end else if (pick < 95) begin
          load_point($urandom_range(4 * NSEG - 1), rand_coord(), rand_coord(),
                     rand_coord());
        end else begin
          send_beat(ACT_UNUSED, PW'($urandom), SW'($urandom),
                    (T_FRAC+1)'($urandom), $urandom, $urandom, $urandom);
        end
      end
    end

    // Drain, let the pipeline settle, then close out
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    end_of_run <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Covered %0d point loads, %0d curve points and %0d slopes", loads_done,
             points_done, slopes_done);
    $display("across free flow, sparse input, heavy output stall and mixed pacing");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/cbez_pkg.sv
rtl/cbez_lerp.sv
rtl/cubic_bezier_point_and_slope_core.sv
test/cbez_result_checker.sv
test/tb_cubic_bezier_point_and_slope_core.sv
